@@ rtl/core/rri_pkg.sv @@
package rri_pkg;

  localparam logic [1:0] OP_GO   = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_WEST = 2'd1;
  localparam logic [1:0] DIR_EAST = 2'd2;

  localparam logic REG_ACTIVE_LEVEL = 1'b0;
  localparam logic REG_DEAD_TIME    = 1'b1;

  localparam logic [15:0] DEAD_TIME_RESET = 16'd1000;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] direction;
  } in_word_t;

  typedef struct packed {
    logic west_drive;
    logic east_drive;
    logic moving;
    logic last_was_west;
  } out_word_t;

endpackage

@@ rtl/core/reversing_relay_interlock.sv @@
// Channel  Direction  Signals
// in       input      in_valid, in_ready, in_data (opcode, direction)
// out      output     out_valid, out_ready, out_data (drives, moving, last_was_west)
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// One word per cycle sustained while out_ready stays high; each word passes through
// the input register, then the state update into the output register.
// Synchronous active-low reset; the relay state and both valid flags reset together (data registers are not reset).
// A stalled output holds the update stage; the input register still takes one
// more word while the output waits. cfg is always ready.
module reversing_relay_interlock (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rri_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rri_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import rri_pkg::*;

  logic        active_level_r;
  logic [15:0] dead_time_r;

  logic      s1_valid_r;
  in_word_t  s1_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t out_data_nxt;
  logic      advance;

  logic [1:0]  cur_r, cur_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic        stopped_r, stopped_nxt;
  logic        moving_r, moving_nxt;
  logic        west_r, west_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    logic [1:0] dir;
    logic       do_start;
    dir         = (s1_data_r.direction == 2'd3) ? DIR_STOP : s1_data_r.direction;
    cur_nxt     = cur_r;
    pend_nxt    = pend_r;
    stopped_nxt = stopped_r;
    moving_nxt  = moving_r;
    west_nxt    = west_r;
    elapsed_nxt = elapsed_r;
    do_start    = 1'b0;
    case (s1_data_r.opcode)
      OP_GO: begin
        if (dir != cur_r && cur_r != DIR_STOP) begin
          moving_nxt = 1'b0;
          if (!stopped_r) begin
            stopped_nxt = 1'b1;
            elapsed_nxt = '0;
          end
        end
        pend_nxt = dir;
        if (dir == cur_r || cur_r == DIR_STOP) begin
          cur_nxt  = dir;
          do_start = 1'b1;
        end
      end
      OP_STOP: begin
        pend_nxt   = DIR_STOP;
        moving_nxt = 1'b0;
        if (!stopped_r) begin
          stopped_nxt = 1'b1;
          elapsed_nxt = '0;
        end
      end
      OP_TICK: begin
        if (elapsed_r != ELAPSED_MAX) begin
          elapsed_nxt = elapsed_r + 16'd1;
        end
        if (cur_r != DIR_STOP && stopped_r && elapsed_nxt >= dead_time_r) begin
          cur_nxt = DIR_STOP;
        end
        if (pend_r != DIR_STOP && cur_nxt == DIR_STOP) begin
          cur_nxt  = pend_r;
          do_start = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (do_start) begin
      stopped_nxt = 1'b0;
      moving_nxt  = (cur_nxt != DIR_STOP);
      if (cur_nxt == DIR_WEST) begin
        west_nxt = 1'b1;
      end
      if (cur_nxt == DIR_EAST) begin
        west_nxt = 1'b0;
      end
    end
    out_data_nxt.west_drive    = (moving_nxt && cur_nxt == DIR_WEST) ?
                                 active_level_r : !active_level_r;
    out_data_nxt.east_drive    = (moving_nxt && cur_nxt == DIR_EAST) ?
                                 active_level_r : !active_level_r;
    out_data_nxt.moving        = moving_nxt;
    out_data_nxt.last_was_west = west_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= 1'b0;
      dead_time_r    <= DEAD_TIME_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      cur_r          <= DIR_STOP;
      pend_r         <= DIR_STOP;
      stopped_r      <= 1'b1;
      moving_r       <= 1'b0;
      west_r         <= 1'b0;
      elapsed_r      <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_ACTIVE_LEVEL) begin
          active_level_r <= cfg_data[0];
        end
        if (cfg_index == REG_DEAD_TIME) begin
          dead_time_r <= cfg_data;
        end
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        cur_r       <= cur_nxt;
        pend_r      <= pend_nxt;
        stopped_r   <= stopped_nxt;
        moving_r    <= moving_nxt;
        west_r      <= west_nxt;
        elapsed_r   <= elapsed_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_moving_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> cur_r != DIR_STOP)
    else $error("relay energized with no direction");

  a_pending_implies_cur: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != DIR_STOP |-> cur_r != DIR_STOP)
    else $error("queued direction left idle");

  a_one_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.moving) |-> out_data_r.west_drive != out_data_r.east_drive)
    else $error("both relays at the same level while moving");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rri_pkg::*;

  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam logic [1:0] DIR_UNDEF = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_WORDS = 230;
  localparam int unsigned LONG_TICKS = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  in_word_t cmd_q[$];
  out_word_t drive_expect_q[$];

  // model of the interlock
  logic cfg_level = 1'b0;
  logic [15:0] cfg_dead = DEAD_TIME_RESET;
  logic [1:0] rly_dir = DIR_STOP;
  logic [1:0] queued_dir = DIR_STOP;
  logic halted = 1'b1;
  logic running = 1'b0;
  logic west_last = 1'b0;
  logic [15:0] ms_elapsed = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic hold_armed = 1'b0;
  logic hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_words_in = 0;
  int unsigned n_words_out = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_errors = 0;

  reversing_relay_interlock u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void halt_motor();
    queued_dir = DIR_STOP;
    running = 1'b0;
    if (!halted) begin
      halted = 1'b1;
      ms_elapsed = '0;
    end
  endfunction

  function automatic void energize();
    halted = 1'b0;
    running = (rly_dir != DIR_STOP);
    if (rly_dir == DIR_WEST) west_last = 1'b1;
    if (rly_dir == DIR_EAST) west_last = 1'b0;
  endfunction

  function automatic out_word_t interlock_step(input in_word_t w);
    logic [1:0] dir;
    out_word_t r;
    dir = (w.direction == DIR_UNDEF) ? DIR_STOP : w.direction;
    case (w.opcode)
      OP_GO: begin
        if (dir != rly_dir && rly_dir != DIR_STOP) halt_motor();
        queued_dir = dir;
        if (dir == rly_dir || rly_dir == DIR_STOP) begin
          rly_dir = dir;
          energize();
        end
      end
      OP_STOP: halt_motor();
      OP_TICK: begin
        if (ms_elapsed != ELAPSED_MAX) ms_elapsed = ms_elapsed + 16'd1;
        if (rly_dir != DIR_STOP && halted && ms_elapsed >= cfg_dead) rly_dir = DIR_STOP;
        if (queued_dir != DIR_STOP && rly_dir == DIR_STOP) begin
          rly_dir = queued_dir;
          energize();
        end
      end
      default: ;
    endcase
    r.west_drive = (running && rly_dir == DIR_WEST) ? cfg_level : ~cfg_level;
    r.east_drive = (running && rly_dir == DIR_EAST) ? cfg_level : ~cfg_level;
    r.moving = running;
    r.last_was_west = west_last;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        drive_expect_q.push_back(interlock_step(in_data));
        n_words_in++;
      end
      if (out_valid && out_ready) begin
        n_words_out++;
        if (drive_expect_q.size() == 0) begin
          $error("unexpected output word %b", out_data);
          n_errors++;
        end else begin
          want = drive_expect_q.pop_front();
          if (out_data.west_drive !== want.west_drive) begin
            $error("west_drive: expected %b, got %b", want.west_drive, out_data.west_drive);
            n_errors++;
          end
          if (out_data.east_drive !== want.east_drive) begin
            $error("east_drive: expected %b, got %b", want.east_drive, out_data.east_drive);
            n_errors++;
          end
          if (out_data.moving !== want.moving) begin
            $error("moving: expected %b, got %b", want.moving, out_data.moving);
            n_errors++;
          end
          if (out_data.last_was_west !== want.last_was_west) begin
            $error("last_was_west: expected %b, got %b", want.last_was_west,
                   out_data.last_was_west);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [1:0] dir);
    in_word_t w;
    w.opcode = op;
    w.direction = dir;
    cmd_q.push_back(w);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned pick;
    in_word_t w;
    repeat (count) begin
      pick = $urandom_range(99);
      w.direction = 2'($urandom_range(3));
      if (pick < 50) w.opcode = OP_TICK;
      else if (pick < 78) w.opcode = OP_GO;
      else if (pick < 94) w.opcode = OP_STOP;
      else w.opcode = OP_UNDEF;
      cmd_q.push_back(w);
    end
  endtask

  task automatic settle();
    while (cmd_q.size() != 0 || in_valid || drive_expect_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ACTIVE_LEVEL) cfg_level = val[0];
    else cfg_dead = val;
    n_cfg_writes++;
    @(negedge clk);
  endtask

  task automatic random_phase(input logic level, input logic [15:0] dead);
    settle();
    write_reg(REG_ACTIVE_LEVEL, {15'd0, level});
    write_reg(REG_DEAD_TIME, dead);
    queue_random(PHASE_WORDS);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 23;
    rx_idle_pct = 74;

    // reset configuration: undefined codes, reversal, same direction while waiting
    push_cmd(OP_UNDEF, DIR_UNDEF);
    push_cmd(OP_GO, DIR_UNDEF);
    push_cmd(OP_STOP, DIR_EAST);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_TICK, DIR_UNDEF);
    push_cmd(OP_GO, DIR_EAST);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_STOP, DIR_WEST);
    push_cmd(OP_GO, DIR_EAST);
    push_cmd(OP_TICK, DIR_EAST);
    push_cmd(OP_TICK, DIR_STOP);
    settle();
    // inverted drive, zero dead time
    write_reg(REG_ACTIVE_LEVEL, 16'd1);
    write_reg(REG_DEAD_TIME, 16'd0);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_GO, DIR_EAST);
    push_cmd(OP_TICK, DIR_WEST);
    push_cmd(OP_STOP, DIR_STOP);
    push_cmd(OP_TICK, DIR_STOP);
    push_cmd(OP_GO, DIR_EAST);
    settle();
    write_reg(REG_DEAD_TIME, 16'd2);
    push_cmd(OP_GO, DIR_EAST);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_TICK, DIR_EAST);
    push_cmd(OP_TICK, DIR_WEST);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_TICK, DIR_STOP);
    push_cmd(OP_STOP, DIR_UNDEF);
    push_cmd(OP_GO, DIR_STOP);

    random_phase(1'b0, 16'd1);
    random_phase(1'b1, 16'd5);
    settle();
    tx_idle_pct = 74;
    rx_idle_pct = 23;
    random_phase(1'b0, 16'($urandom_range(2, 12)));
    random_phase(1'b1, 16'd3);
    settle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(1'b1, 16'($urandom_range(1, 8)));
    hold_armed = 1'b1;

    // long dead time counted out tick by tick before the queued reversal starts
    settle();
    write_reg(REG_ACTIVE_LEVEL, 16'd0);
    write_reg(REG_DEAD_TIME, 16'd180);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_GO, DIR_EAST);
    repeat (LONG_TICKS) push_cmd(OP_TICK, DIR_STOP);
    push_cmd(OP_GO, DIR_WEST);
    push_cmd(OP_TICK, DIR_WEST);
    push_cmd(OP_STOP, DIR_EAST);
    settle();
    repeat (10) @(negedge clk);

    n_errors += drive_expect_q.size();
    $display("%0d commands in, %0d status words checked, %0d register writes", n_words_in,
             n_words_out, n_cfg_writes);
    $display("covered both drive polarities, dead time 0 to 180, idle mixes and a long stall");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ reversing_relay_interlock.f @@
rtl/core/rri_pkg.sv
rtl/core/reversing_relay_interlock.sv
dv/tb_top.sv
